>>> src/twelve_hour_clock_vfd_scanner_defines.svh
// Assertion macros for the clock scanner.
`ifndef TWELVE_HOUR_CLOCK_VFD_SCANNER_DEFINES_SVH
`define TWELVE_HOUR_CLOCK_VFD_SCANNER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define THCVFD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define THCVFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/thcvfd_pkg.sv
package thcvfd_pkg;

    localparam int DISPLAY_POSITIONS = 9;
    localparam logic [3:0] TOP_POS = 4'(DISPLAY_POSITIONS - 1);
    localparam int DIGIT_COUNT = DISPLAY_POSITIONS - 1;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SCAN = 1'b1;

    localparam logic [3:0] DASH_CODE  = 4'd10;
    localparam logic [3:0] RESET_DIGIT = 4'd1;
    localparam logic [6:0] MAX_SET    = 7'd99;
    localparam logic [6:0] ROLL_LIMIT = 7'd59;
    localparam logic [6:0] HOUR_NOON  = 7'd12;
    localparam logic [6:0] HOUR_TENS  = 7'd10;
    localparam logic [6:0] HOUR_FIRST = 7'd1;
    localparam logic [6:0] RESET_TIME = 7'd11;
    localparam logic [7:0] TICK_CMP_RESET = 8'd124;
    localparam logic [7:0] PM_SEGMENT = 8'd128;

    typedef struct packed {
        logic [3:0] scan_position;
        logic [7:0] segment_word;
        logic [8:0] grid_word;
    } result_t;

    function automatic logic [7:0] seg_font(input logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'd0:    s = 8'd238;
            4'd1:    s = 8'd36;
            4'd2:    s = 8'd186;
            4'd3:    s = 8'd182;
            4'd4:    s = 8'd116;
            4'd5:    s = 8'd214;
            4'd6:    s = 8'd222;
            4'd7:    s = 8'd164;
            4'd8:    s = 8'd254;
            4'd9:    s = 8'd244;
            4'd10:   s = 8'd16;
            default: s = 8'd0;
        endcase
        return s;
    endfunction

    // exact for values below 128
    function automatic logic [3:0] div10(input logic [6:0] v);
        logic [14:0] p;
        p = 15'(v) * 15'd205;
        return 4'(p >> 11);
    endfunction

    function automatic logic [3:0] mod10(input logic [6:0] v);
        logic [6:0] q10;
        q10 = 7'(div10(v)) * 7'd10;
        return 4'(v - q10);
    endfunction

endpackage

>>> src/thcvfd_core.sv
module thcvfd_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    item_en,
    input  logic                    cmd,
    input  logic                    hour_button_level,
    input  logic                    minute_button_level,
    input  logic [7:0]              tick_compare,
    output thcvfd_pkg::result_t     result
);
    import thcvfd_pkg::*;

    logic [7:0] presc_reg, presc_next;
    logic [5:0] sec_reg, sec_next;
    logic [6:0] min_reg, min_next;
    logic [6:0] hour_reg, hour_next;
    logic       pm_reg, pm_next;
    logic       hte_reg, hte_next;
    logic [3:0] pos_reg, pos_next;
    logic [3:0] digit_reg [DIGIT_COUNT];
    logic [3:0] digit_next [DIGIT_COUNT];
    logic       refresh_reg, refresh_next;
    logic       harm_reg, harm_next;
    logic       marm_reg, marm_next;

    logic [6:0] sec_w;

    always_comb begin
        if (pos_reg == TOP_POS) begin
            result.grid_word    = 9'(1) << TOP_POS;
            result.segment_word = PM_SEGMENT | 8'(pm_reg);
        end else if (pos_reg < TOP_POS) begin
            result.grid_word    = (pos_reg == TOP_POS - 4'd1 && !hte_reg) ? 9'd0
                                                                        : 9'(1) << pos_reg;
            result.segment_word = seg_font(digit_reg[pos_reg[2:0]]);
        end else begin
            result.grid_word    = 9'd0;
            result.segment_word = 8'd0;
        end
        result.scan_position = pos_reg;
    end

    always_comb begin
        presc_next   = presc_reg;
        sec_w        = 7'(sec_reg);
        min_next     = min_reg;
        hour_next    = hour_reg;
        pm_next      = pm_reg;
        hte_next     = hte_reg;
        pos_next     = pos_reg;
        refresh_next = refresh_reg;
        harm_next    = harm_reg;
        marm_next    = marm_reg;
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            digit_next[i] = digit_reg[i];
        end
        if (item_en) begin
            if (cmd == CMD_TICK) begin
                if (presc_reg == tick_compare) begin
                    presc_next   = 8'd0;
                    refresh_next = 1'b1;
                    sec_w        = sec_w + 7'd1;
                    if (sec_w > ROLL_LIMIT) begin
                        min_next = min_next + 7'd1;
                        sec_w    = 7'd0;
                    end
                    if (min_next > ROLL_LIMIT) begin
                        hour_next = hour_next + 7'd1;
                        min_next  = 7'd0;
                        if (hour_next == HOUR_NOON) begin
                            pm_next = !pm_next;
                        end
                    end
                    hte_next = (hour_next >= HOUR_TENS);
                    if (hour_next > HOUR_NOON) begin
                        hour_next = HOUR_FIRST;
                    end
                end else begin
                    presc_next = presc_reg + 8'd1;
                end
            end else begin
                pos_next = (pos_reg == 4'd0 || pos_reg > TOP_POS) ? TOP_POS
                                                                 : pos_reg - 4'd1;
                if (!hour_button_level) begin
                    harm_next = 1'b1;
                end
                if (!minute_button_level) begin
                    marm_next = 1'b1;
                end
                if (hour_button_level && harm_next) begin
                    sec_w = 7'd0;
                    if (hour_next < MAX_SET) begin
                        hour_next = hour_next + 7'd1;
                    end
                    if (hour_next == HOUR_NOON) begin
                        pm_next = !pm_next;
                    end
                    refresh_next = 1'b1;
                    harm_next    = 1'b0;
                end
                if (minute_button_level && marm_next) begin
                    sec_w = 7'd0;
                    if (min_next < MAX_SET) begin
                        min_next = min_next + 7'd1;
                    end
                    refresh_next = 1'b1;
                    marm_next    = 1'b0;
                end
                if (refresh_next) begin
                    digit_next[7] = div10(hour_next);
                    digit_next[6] = mod10(hour_next);
                    digit_next[5] = DASH_CODE;
                    digit_next[4] = div10(min_next);
                    digit_next[3] = mod10(min_next);
                    digit_next[2] = DASH_CODE;
                    digit_next[1] = div10(sec_w);
                    digit_next[0] = mod10(sec_w);
                    refresh_next  = 1'b0;
                end
            end
        end
        sec_next = sec_w[5:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            presc_reg   <= 8'd0;
            sec_reg     <= 6'd0;
            min_reg     <= RESET_TIME;
            hour_reg    <= RESET_TIME;
            pm_reg      <= 1'b0;
            hte_reg     <= 1'b1;
            pos_reg     <= TOP_POS;
            refresh_reg <= 1'b1;
            harm_reg    <= 1'b0;
            marm_reg    <= 1'b0;
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                digit_reg[i] <= RESET_DIGIT;
            end
        end else begin
            presc_reg   <= presc_next;
            sec_reg     <= sec_next;
            min_reg     <= min_next;
            hour_reg    <= hour_next;
            pm_reg      <= pm_next;
            hte_reg     <= hte_next;
            pos_reg     <= pos_next;
            refresh_reg <= refresh_next;
            harm_reg    <= harm_next;
            marm_reg    <= marm_next;
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                digit_reg[i] <= digit_next[i];
            end
        end
    end

endmodule

>>> src/thcvfd_out.sv
module thcvfd_out (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load,
    input  thcvfd_pkg::result_t     result_in,
    input  logic                    m_tready,
    output logic                    m_tvalid,
    output thcvfd_pkg::result_t     result_out
);
    import thcvfd_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result_in;
        end
    end

    assign m_tvalid   = valid_reg;
    assign result_out = data_reg;

endmodule

>>> src/twelve_hour_clock_vfd_scanner.sv
// Twelve-hour clock driving a multiplexed nine-position display.
// Input stream: s_tuser[0] is the item kind (tick or scan step); s_tdata carries
// the hour and minute button levels (low = pressed) sampled with a scan step.
// A tick advances the prescaler and, once per tick_compare + 1 ticks, the time.
// A scan step yields one result on the output stream: the grid word, segment
// word and position to drive, then steps to the next position and takes
// button releases. Ticks yield no result.
// cfg_wr_en / cfg_wr_data load tick_compare; write only while idle.
// Path: an accepted item waits in the input register until the core takes it;
// a scan step's result is then registered and drives m_tvalid/m_tdata.
// Throughput: one item per cycle unless a held result stalls a scan step, set by
// the single input register feeding the update logic and single result register.
// Reset: time 11:11:00 AM, position 8, digit buffer all ones, compare value 124,
// both channels empty.
// Stall: a held result blocks only a scan step waiting in the input register;
// s_tready drops until m_tready frees the result register.
`include "twelve_hour_clock_vfd_scanner_defines.svh"

module twelve_hour_clock_vfd_scanner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] hour_button_level, [1] minute_button_level
    input  logic [0:0]  s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [8:0] grid_word, [16:9] segment_word, [20:17] scan_position
);
    import thcvfd_pkg::*;

    logic       in_scan;
    logic [7:0] tick_cmp_reg;
    logic       in_valid_reg, in_valid_next;
    logic       in_cmd_reg;
    logic       in_hb_reg;
    logic       in_mb_reg;
    logic       advance;
    logic       s_accept;
    result_t    core_result;
    result_t    out_result;

    assign in_scan  = in_cmd_reg == CMD_SCAN;
    assign advance  = in_valid_reg && !(in_scan && m_tvalid && !m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            tick_cmp_reg <= TICK_CMP_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_wr_en) begin
                tick_cmp_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_cmd_reg <= s_tuser[0];
            in_hb_reg  <= s_tdata[0];
            in_mb_reg  <= s_tdata[1];
        end
    end

    thcvfd_core u_core (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .item_en             (advance),
        .cmd                 (in_cmd_reg),
        .hour_button_level   (in_hb_reg),
        .minute_button_level (in_mb_reg),
        .tick_compare        (tick_cmp_reg),
        .result              (core_result)
    );

    thcvfd_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance && in_scan),
        .result_in  (core_result),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .result_out (out_result)
    );

    assign m_tdata = {3'd0, out_result.scan_position, out_result.segment_word,
                      out_result.grid_word};

    `THCVFD_ASSERT_NOW(a_pos_range, m_tvalid, m_tdata[20:17] <= TOP_POS,
        "scan position out of range")
    `THCVFD_ASSERT_NOW(a_grid_onehot, m_tvalid, $onehot0(m_tdata[8:0]),
        "grid word has more than one enable")
    `THCVFD_ASSERT_NOW(a_top_grid, m_tvalid && m_tdata[20:17] == TOP_POS,
        m_tdata[8:0] == 9'h100 && m_tdata[16:10] == 7'h40, "indicator position word wrong")
    `THCVFD_ASSERT_NOW(a_stall_block, in_valid_reg && in_scan && m_tvalid && !m_tready,
        !s_tready, "input taken while scan result is blocked")
    `THCVFD_ASSERT_NEXT(a_scan_result, advance && in_scan, m_tvalid,
        "scan step produced no result")

endmodule
